FILE: rtl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

   // angle units: hundredths of a degree
   localparam int PFC_FULL_TURN = 36000;
   localparam int PFC_HALF_TURN = 18000;
   localparam int PFC_QUARTER   = 9000;

   // trig format Q2.15 and the internal series format Q1.30
   localparam int PFC_TRIG_FRAC_BITS = 15;
   localparam int PFC_TRIG_W         = PFC_TRIG_FRAC_BITS + 3;
   localparam int PFC_WORK_BITS      = 30;
   localparam int PFC_RND_SHIFT      = PFC_WORK_BITS - PFC_TRIG_FRAC_BITS;
   localparam longint unsigned PFC_ONE = 64'd1 << PFC_WORK_BITS;

   // pi in Q2.30, split so that m * pi / 180 deg needs only narrow products
   localparam longint unsigned PFC_PI_WORK   = 64'd3373259426;
   localparam longint unsigned PFC_PI_QUOT   = PFC_PI_WORK / PFC_HALF_TURN;
   localparam longint unsigned PFC_PI_REM    = PFC_PI_WORK % PFC_HALF_TURN;
   localparam int              PFC_ANG_SHIFT = 26;
   localparam longint unsigned PFC_ANG_RECIP = (64'd1 << PFC_ANG_SHIFT) / PFC_HALF_TURN;

   // horner divisors of the sine series and their reciprocals (scaled by 2^32)
   localparam int PFC_HORNER_STEPS = 5;
   localparam int PFC_RECIP_SHIFT  = 32;
   localparam int unsigned PFC_HORNER_DIV [PFC_HORNER_STEPS] = '{110, 72, 42, 20, 6};
   localparam longint unsigned PFC_HORNER_RECIP [PFC_HORNER_STEPS] = '{
      (64'd1 << PFC_RECIP_SHIFT) / PFC_HORNER_DIV[0],
      (64'd1 << PFC_RECIP_SHIFT) / PFC_HORNER_DIV[1],
      (64'd1 << PFC_RECIP_SHIFT) / PFC_HORNER_DIV[2],
      (64'd1 << PFC_RECIP_SHIFT) / PFC_HORNER_DIV[3],
      (64'd1 << PFC_RECIP_SHIFT) / PFC_HORNER_DIV[4]
   };

   // register stages of the sine evaluator
   localparam int PFC_SIN_LAT = 3 * PFC_HORNER_STEPS + 6;

   // output limits
   localparam int PFC_POS_MAX = 4194303;
   localparam int PFC_POS_MIN = -4194304;

   localparam logic [15:0] PFC_LEVER_RESET = 16'd2352;

   typedef logic signed [PFC_TRIG_W-1:0] trig_type;

   // quadrant-reduced angle handed to the sine evaluator
   typedef struct packed {
      logic [13:0] m;
      logic        neg;
   } angle_type;

   typedef enum logic [0:0] {
      CSR_FIELD_MODE = 1'b0,
      CSR_LEVER_ARM  = 1'b1
   } csr_index_type;

   // sine of a constant angle, same series and truncations as the hardware
   function automatic longint pfc_sin_ref(input longint angle);
      longint r;
      longint q;
      longint m;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned v;
      r = angle % PFC_FULL_TURN;
      if (r < 0) r = r + PFC_FULL_TURN;
      q = r / PFC_QUARTER;
      m = r % PFC_QUARTER;
      if (q % 2 == 1) m = PFC_QUARTER - m;
      x  = longint'(m) * PFC_PI_WORK / PFC_HALF_TURN;
      x2 = (x * x) >> PFC_WORK_BITS;
      t  = PFC_ONE;
      for (int k = 0; k < PFC_HORNER_STEPS; k++) begin
         t = PFC_ONE - ((x2 * t) >> PFC_WORK_BITS) / PFC_HORNER_DIV[k];
      end
      v = (x * t) >> PFC_WORK_BITS;
      v = (v + (64'd1 << (PFC_RND_SHIFT - 1))) >> PFC_RND_SHIFT;
      return (q >= 2) ? -longint'(v) : longint'(v);
   endfunction

   // fixed angles: field rotation of 60 and 120 degrees, lever reference of -30
   localparam trig_type PFC_COS_F0  = PFC_TRIG_W'(pfc_sin_ref(6000 + PFC_QUARTER));
   localparam trig_type PFC_SIN_F0  = PFC_TRIG_W'(pfc_sin_ref(6000));
   localparam trig_type PFC_COS_F1  = PFC_TRIG_W'(pfc_sin_ref(12000 + PFC_QUARTER));
   localparam trig_type PFC_SIN_F1  = PFC_TRIG_W'(pfc_sin_ref(12000));
   localparam trig_type PFC_COS_M30 = PFC_TRIG_W'(pfc_sin_ref(-3000 + PFC_QUARTER));
   localparam trig_type PFC_SIN_M30 = PFC_TRIG_W'(pfc_sin_ref(-3000));

endpackage

`default_nettype wire

FILE: rtl/pose_frame_conversion_top.sv
`default_nettype none

// Pose frame conversion: raw sensor pose (x, y, heading) to a world pose.
// Input: a transaction is taken at each clock edge with start high and busy
// low. busy never rises, so one pose can be given on every clock cycle.
// Output: each result is shown on rsp_world_x, rsp_world_y and rsp_heading
// for one cycle with rsp_strobe high. Results come out in the order taken,
// after the input, sine evaluator, lever and output registers.
// The receiver cannot stall the block; results are never held back.
// The latency comes from the pipelined sine evaluator (21 register stages:
// radian conversion, squaring, five Horner steps of three stages each, final
// product, rounding) and input, lever and output registers, with rotation in
// parallel. Every stage is registered, so throughput is one pose per clock.
// Configuration: csr_valid/csr_ready (always ready) with csr_index and
// csr_wdata; index 0 is the field mode, index 1 the lever arm. Write only
// while no transaction is in flight.
// Reset clears all poses in flight and returns field mode to 0 and the lever
// arm to 2352 (147 mm).
module pose_frame_conversion_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic signed [21:0]     req_raw_x,
   input  wire logic signed [21:0]     req_raw_y,
   input  wire logic signed [16:0]     req_raw_heading,
   output logic                        rsp_strobe,
   output logic signed [22:0]          rsp_world_x,
   output logic signed [22:0]          rsp_world_y,
   output logic signed [15:0]          rsp_heading,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire pfc_pkg::csr_index_type csr_index,
   input  wire logic [15:0]            csr_wdata
);
   import pfc_pkg::*;

   localparam int PROD_W = 22 + PFC_TRIG_W;
   localparam int ROT_W  = PROD_W + 2;
   localparam int DIFF_W = PFC_TRIG_W + 1;
   localparam int LEV_W  = 17 + DIFF_W;
   localparam int VLD_N  = PFC_SIN_LAT + 2;

   // configuration registers
   logic        field_mode_ff;
   logic [15:0] lever_ff;

   // input register
   logic signed [21:0] x_ff;
   logic signed [21:0] y_ff;
   logic signed [16:0] hdg_ff;
   logic               vld_ff [VLD_N];

   // heading reduction
   logic signed [17:0] h_ext;
   logic [15:0]        r_sin;
   logic [16:0]        r_cos_raw;
   logic [15:0]        r_cos;
   angle_type          ang_sin;
   angle_type          ang_cos;
   trig_type           sin_h;
   trig_type           cos_h;

   // heading wrap and clamp
   logic signed [17:0] hw_a;
   logic signed [17:0] hw_b;
   logic signed [15:0] hw_in;
   logic signed [15:0] hdg_dly_ff [PFC_SIN_LAT + 1];

   // rotation
   trig_type              cf_sel;
   trig_type              sf_sel;
   logic signed [PROD_W-1:0] px_c_ff, py_s_ff, px_s_ff, py_c_ff;
   logic signed [ROT_W-1:0]  rot_y_in;
   logic signed [ROT_W-1:0]  rot_x_dly_ff [PFC_SIN_LAT];
   logic signed [ROT_W-1:0]  rot_y_dly_ff [PFC_SIN_LAT];

   // lever arm
   logic signed [DIFF_W-1:0] dc_in, ds_in;
   logic signed [LEV_W-1:0]  lx_ff, ly_ff;

   // output
   logic signed [ROT_W-1:0] sum_x, sum_y, shx, shy;
   logic signed [22:0]      wx_in, wy_in;
   logic                    strobe_ff;
   logic signed [22:0]      wx_ff, wy_ff;
   logic signed [15:0]      hdg_out_ff;

   // split a reduced angle into quadrant offset and sign
   function automatic angle_type quad_split(input logic [15:0] r);
      angle_type   res;
      logic [1:0]  q;
      logic [13:0] off;
      if (r >= 16'(3 * PFC_QUARTER)) begin
         q   = 2'd3;
         off = 14'(r - 16'(3 * PFC_QUARTER));
      end else if (r >= 16'(2 * PFC_QUARTER)) begin
         q   = 2'd2;
         off = 14'(r - 16'(2 * PFC_QUARTER));
      end else if (r >= 16'(PFC_QUARTER)) begin
         q   = 2'd1;
         off = 14'(r - 16'(PFC_QUARTER));
      end else begin
         q   = 2'd0;
         off = 14'(r);
      end
      res.m   = q[0] ? 14'(PFC_QUARTER) - off : off;
      res.neg = q[1];
      return res;
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff <= 1'b0;
         lever_ff      <= PFC_LEVER_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FIELD_MODE: field_mode_ff <= csr_wdata[0];
            CSR_LEVER_ARM:  lever_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // transaction valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VLD_N; i++) vld_ff[i] <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int i = 1; i < VLD_N; i++) vld_ff[i] <= vld_ff[i-1];
         strobe_ff <= vld_ff[VLD_N-1];
      end
   end

   // reduce the heading to [0, 360) degrees for sine and cosine
   always_comb begin
      h_ext = 18'(hdg_ff);
      if (h_ext < -PFC_FULL_TURN) begin
         r_sin = 16'(h_ext + 18'(2 * PFC_FULL_TURN));
      end else if (h_ext < 0) begin
         r_sin = 16'(h_ext + 18'(PFC_FULL_TURN));
      end else if (h_ext >= PFC_FULL_TURN) begin
         r_sin = 16'(h_ext - 18'(PFC_FULL_TURN));
      end else begin
         r_sin = 16'(h_ext);
      end
      r_cos_raw = 17'(r_sin) + 17'(PFC_QUARTER);
      r_cos     = (r_cos_raw >= 17'(PFC_FULL_TURN)) ? 16'(r_cos_raw - 17'(PFC_FULL_TURN))
                                                    : 16'(r_cos_raw);
      ang_sin = quad_split(r_sin);
      ang_cos = quad_split(r_cos);
   end

   pfc_sin_unit u_sin (
      .clock     (clock),
      .angle     (ang_sin),
      .sin_value (sin_h)
   );

   pfc_sin_unit u_cos (
      .clock     (clock),
      .angle     (ang_cos),
      .sin_value (cos_h)
   );

   // wrap once, then clamp to +-180 degrees
   always_comb begin
      hw_a = 18'(hdg_ff);
      if (hw_a > PFC_HALF_TURN) hw_a = hw_a - 18'(PFC_FULL_TURN);
      hw_b = hw_a;
      if (hw_b < -PFC_HALF_TURN) hw_b = hw_b + 18'(PFC_FULL_TURN);
      if (hw_b > PFC_HALF_TURN) begin
         hw_in = 16'(PFC_HALF_TURN);
      end else if (hw_b < -PFC_HALF_TURN) begin
         hw_in = 16'(-PFC_HALF_TURN);
      end else begin
         hw_in = 16'(hw_b);
      end
   end

   // field rotation constants
   always_comb begin
      cf_sel   = field_mode_ff ? PFC_COS_F1 : PFC_COS_F0;
      sf_sel   = field_mode_ff ? PFC_SIN_F1 : PFC_SIN_F0;
      rot_y_in = ROT_W'(px_s_ff) + ROT_W'(py_c_ff);
   end

   // lever term differences against the -30 degree reference
   always_comb begin
      dc_in = DIFF_W'(cos_h) - DIFF_W'(PFC_COS_M30);
      ds_in = DIFF_W'(sin_h) - DIFF_W'(PFC_SIN_M30);
   end

   // final sums, round to nearest (ties up) and saturate
   always_comb begin
      sum_x = rot_x_dly_ff[PFC_SIN_LAT-1] + ROT_W'(lx_ff);
      sum_y = rot_y_dly_ff[PFC_SIN_LAT-1] - ROT_W'(ly_ff);
      shx   = (sum_x + ROT_W'(1 << (PFC_TRIG_FRAC_BITS - 1))) >>> PFC_TRIG_FRAC_BITS;
      shy   = (sum_y + ROT_W'(1 << (PFC_TRIG_FRAC_BITS - 1))) >>> PFC_TRIG_FRAC_BITS;
      if (shx > PFC_POS_MAX) begin
         wx_in = 23'(PFC_POS_MAX);
      end else if (shx < PFC_POS_MIN) begin
         wx_in = 23'(PFC_POS_MIN);
      end else begin
         wx_in = 23'(shx);
      end
      if (shy > PFC_POS_MAX) begin
         wy_in = 23'(PFC_POS_MAX);
      end else if (shy < PFC_POS_MIN) begin
         wy_in = 23'(PFC_POS_MIN);
      end else begin
         wy_in = 23'(shy);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         x_ff   <= req_raw_x;
         y_ff   <= req_raw_y;
         hdg_ff <= req_raw_heading;
      end

      hdg_dly_ff[0] <= hw_in;
      for (int i = 1; i <= PFC_SIN_LAT; i++) hdg_dly_ff[i] <= hdg_dly_ff[i-1];

      px_c_ff <= PROD_W'(x_ff) * PROD_W'(cf_sel);
      py_s_ff <= PROD_W'(y_ff) * PROD_W'(sf_sel);
      px_s_ff <= PROD_W'(x_ff) * PROD_W'(sf_sel);
      py_c_ff <= PROD_W'(y_ff) * PROD_W'(cf_sel);

      rot_x_dly_ff[0] <= ROT_W'(px_c_ff) - ROT_W'(py_s_ff);
      rot_y_dly_ff[0] <= field_mode_ff ? rot_y_in : -rot_y_in;
      for (int i = 1; i < PFC_SIN_LAT; i++) begin
         rot_x_dly_ff[i] <= rot_x_dly_ff[i-1];
         rot_y_dly_ff[i] <= rot_y_dly_ff[i-1];
      end

      lx_ff <= LEV_W'(signed'({1'b0, lever_ff})) * LEV_W'(dc_in);
      ly_ff <= LEV_W'(signed'({1'b0, lever_ff})) * LEV_W'(ds_in);

      wx_ff      <= wx_in;
      wy_ff      <= wy_in;
      hdg_out_ff <= hdg_dly_ff[PFC_SIN_LAT];
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_world_x = wx_ff;
   assign rsp_world_y = wy_ff;
   assign rsp_heading = hdg_out_ff;

endmodule

`default_nettype wire

FILE: rtl/pfc_sin_unit.sv
`default_nettype none

module pfc_sin_unit (
   input  wire logic               clock,
   input  wire pfc_pkg::angle_type angle,
   output pfc_pkg::trig_type       sin_value
);
   import pfc_pkg::*;

   localparam int X_DLY   = 3 * PFC_HORNER_STEPS + 2;
   localparam int X2_DLY  = 3 * (PFC_HORNER_STEPS - 1) + 1;
   localparam int NEG_DLY = 3 * PFC_HORNER_STEPS + 5;

   // angle to radians: m * quot + floor(m * rem / 18000)
   logic [30:0] xq_ff;
   logic [25:0] xr_ff;
   logic [30:0] xq2_ff;
   logic [25:0] xr2_ff;
   logic [11:0] xe_ff;
   logic [25:0] xrem_in;
   logic [30:0] x_in;

   logic [30:0] x_dly_ff  [X_DLY];
   logic [31:0] x2_dly_ff [X2_DLY];
   logic        neg_dly_ff [NEG_DLY];

   // horner steps: product, reciprocal product, correction
   logic [31:0] y_a_ff [PFC_HORNER_STEPS];
   logic [61:0] p_b_ff [PFC_HORNER_STEPS];
   logic [31:0] y_b_ff [PFC_HORNER_STEPS];
   logic [30:0] t_c_ff [PFC_HORNER_STEPS];
   logic [30:0] t_src  [PFC_HORNER_STEPS];
   logic [30:0] t_c_in [PFC_HORNER_STEPS];

   logic [30:0] v_ff;
   logic [31:0] v_rnd;
   trig_type    mag;
   trig_type    sin_ff;

   // exact quotient of the radian conversion
   always_comb begin
      xrem_in = xr2_ff - 26'(xe_ff) * 26'(PFC_HALF_TURN);
      x_in    = xq2_ff + 31'(xe_ff) + 31'(xrem_in >= 26'(PFC_HALF_TURN));
   end

   // quotient estimate from the reciprocal, corrected by at most one
   always_comb begin
      for (int k = 0; k < PFC_HORNER_STEPS; k++) begin
         logic [29:0] q_est;
         logic [31:0] rem;
         logic [29:0] q;
         q_est = 30'(p_b_ff[k] >> PFC_RECIP_SHIFT);
         rem   = y_b_ff[k] - 32'(q_est) * 32'(PFC_HORNER_DIV[k]);
         q     = q_est + 30'(rem >= 32'(PFC_HORNER_DIV[k]));
         t_c_in[k] = 31'(PFC_ONE) - 31'(q);
         t_src[k]  = (k == 0) ? 31'(PFC_ONE) : t_c_ff[(k == 0) ? 0 : k - 1];
      end
   end

   // rounding to Q2.15 and sign of the lower half-plane
   always_comb begin
      v_rnd = {1'b0, v_ff} + (32'd1 << (PFC_RND_SHIFT - 1));
      mag   = PFC_TRIG_W'(v_rnd >> PFC_RND_SHIFT);
   end

   always_ff @(posedge clock) begin
      xq_ff  <= 31'(angle.m) * 31'(PFC_PI_QUOT);
      xr_ff  <= 26'(angle.m) * 26'(PFC_PI_REM);
      xq2_ff <= xq_ff;
      xr2_ff <= xr_ff;
      xe_ff  <= 12'((38'(xr_ff) * 38'(PFC_ANG_RECIP)) >> PFC_ANG_SHIFT);

      x_dly_ff[0] <= x_in;
      for (int i = 1; i < X_DLY; i++) x_dly_ff[i] <= x_dly_ff[i-1];

      x2_dly_ff[0] <= 32'((62'(x_dly_ff[0]) * 62'(x_dly_ff[0])) >> PFC_WORK_BITS);
      for (int i = 1; i < X2_DLY; i++) x2_dly_ff[i] <= x2_dly_ff[i-1];

      neg_dly_ff[0] <= angle.neg;
      for (int i = 1; i < NEG_DLY; i++) neg_dly_ff[i] <= neg_dly_ff[i-1];

      for (int k = 0; k < PFC_HORNER_STEPS; k++) begin
         y_a_ff[k] <= 32'((63'(x2_dly_ff[3*k]) * 63'(t_src[k])) >> PFC_WORK_BITS);
         p_b_ff[k] <= 62'(y_a_ff[k]) * 62'(PFC_HORNER_RECIP[k]);
         y_b_ff[k] <= y_a_ff[k];
         t_c_ff[k] <= t_c_in[k];
      end

      v_ff   <= 31'((62'(x_dly_ff[X_DLY-1]) * 62'(t_c_ff[PFC_HORNER_STEPS-1]))
                    >> PFC_WORK_BITS);
      sin_ff <= neg_dly_ff[NEG_DLY-1] ? -mag : mag;
   end

   assign sin_value = sin_ff;

endmodule

`default_nettype wire
